### hw/rtl/cfs_pkg.sv
// cfs_pkg: command codes, queue depth and controller/datapath interface structs
// for the circular FIFO with search. No dependencies.
`default_nettype none

package cfs_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // latch search value
    logic push;       // write word, advance tail
    logic pop;        // advance head, report read data
    logic clear;      // empty the queue
    logic scan_init;  // start scan at head
    logic scan_next;  // advance scan by one entry
    logic scanning;   // read address follows scan pointer
    logic emit;       // present a result next cycle
    logic refused;    // result is a refusal
    logic hit;        // result is a search match
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic match;      // read data equals search value
    logic last;       // current scan entry is the newest
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/cfs_ram.sv
// cfs_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none

module cfs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/cfs_ctrl.sv
// cfs_ctrl: command sequencer for the circular FIFO with search.
// Depends on cfs_pkg.
`default_nettype none

module cfs_ctrl
  import cfs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire dp_status_t       status,
  output logic                  busy,
  output ctrl_cmd_t             ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FIND
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ctl.load = 1'b1;
          unique case (cmd_t'(cmd))
            CMD_PUSH: begin
              ctl.emit = 1'b1;
              if (status.full) begin
                ctl.refused = 1'b1;
              end else begin
                ctl.push = 1'b1;
              end
            end
            CMD_POP: begin
              if (status.empty) begin
                ctl.emit    = 1'b1;
                ctl.refused = 1'b1;
              end else begin
                state_nxt = ST_POP;
              end
            end
            CMD_FIND: begin
              if (status.empty) begin
                ctl.emit = 1'b1;
              end else begin
                ctl.scan_init = 1'b1;
                state_nxt     = ST_FIND;
              end
            end
            CMD_CLEAR: begin
              ctl.clear = 1'b1;
              ctl.emit  = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        ctl.pop   = 1'b1;
        ctl.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_FIND: begin
        ctl.scanning = 1'b1;
        if (status.match) begin
          ctl.emit  = 1'b1;
          ctl.hit   = 1'b1;
          state_nxt = ST_IDLE;
        end else if (status.last) begin
          ctl.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ctl.scan_next = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/cfs_dp.sv
// cfs_dp: ring indices, occupancy, scan pointer, store and result
// registers. Depends on cfs_pkg and cfs_ram.
`default_nettype none

module cfs_dp
  import cfs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic        [DATA_W-1:0] value,
  input  wire ctrl_cmd_t                ctl,
  output dp_status_t                    status,
  output logic                          res_valid,
  output logic             [DATA_W-1:0] res_pop_data,
  output logic                          res_found,
  output logic             [POS_W-1:0]  res_position,
  output logic             [CNT_W-1:0]  res_count,
  output logic                          res_full,
  output logic                          res_empty,
  output logic                          res_refused
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
    ring_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
  endfunction

  logic [AW-1:0]     head_r, head_nxt;
  logic [AW-1:0]     tail_r, tail_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [DATA_W-1:0] value_r;
  logic              valid_r;
  logic [DATA_W-1:0] pop_data_r;
  logic              found_r;
  logic [AW-1:0]     position_r;
  logic              refused_r;

  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign wr_addr = ring_next(tail_r);
  assign rd_addr = ctl.scanning ? ring_next(ptr_r) : head_r;

  cfs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ctl.push),
    .waddr (wr_addr),
    .wdata (value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    k_nxt     = k_r;
    if (ctl.push) begin
      tail_nxt  = wr_addr;
      count_nxt = count_r + CW'(1);
    end
    if (ctl.pop) begin
      head_nxt  = ring_next(head_r);
      count_nxt = count_r - CW'(1);
    end
    if (ctl.clear) begin
      head_nxt  = ring_next(tail_r);
      count_nxt = '0;
    end
    if (ctl.scan_init) begin
      ptr_nxt = head_r;
      k_nxt   = '0;
    end
    if (ctl.scan_next) begin
      ptr_nxt = ring_next(ptr_r);
      k_nxt   = k_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= AW'(DEPTH - 1);
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    k_r   <= k_nxt;
    if (ctl.load) begin
      value_r <= value;
    end
    if (ctl.emit) begin
      pop_data_r <= ctl.pop ? rd_data : '0;
      found_r    <= ctl.hit;
      position_r <= ctl.hit ? k_r : '0;
      refused_r  <= ctl.refused;
    end
  end

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == CW'(DEPTH));
  assign status.match = (rd_data == value_r);
  assign status.last  = ((CW'(k_r) + CW'(1)) == count_r);

  assign res_valid    = valid_r;
  assign res_pop_data = pop_data_r;
  assign res_found    = found_r;
  assign res_position = POS_W'(position_r);
  assign res_count    = CNT_W'(count_r);
  assign res_full     = (count_r == CW'(DEPTH));
  assign res_empty    = (count_r == '0);
  assign res_refused  = refused_r;

endmodule

`default_nettype wire

### hw/rtl/circular_fifo_with_search_core.sv
// Ring-buffer FIFO with search. Push, clear and refused commands: result strobe
// in the cycle after accept, busy never set. Pop: result via the ST_POP state and
// the result register; busy for a single cycle. Find: scans one entry per cycle
// via the store's registered read port; a match at offset k strobes once entries
// 0..k are compared, a miss once all are (if empty, the cycle after accept).
// Synchronous reset empties the queue; store contents are not cleared.
`default_nettype none

module circular_fifo_with_search_core
  import cfs_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic        [CMD_W-1:0]  in_cmd,
  input  wire logic signed [DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed      [DATA_W-1:0] out_pop_data,
  output logic                          out_found,
  output logic             [POS_W-1:0]  out_position,
  output logic             [CNT_W-1:0]  out_count,
  output logic                          out_is_full,
  output logic                          out_is_empty,
  output logic                          out_refused
);

  ctrl_cmd_t         ctl;
  dp_status_t        status;
  logic [DATA_W-1:0] pop_data;

  cfs_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (in_cmd),
    .status (status),
    .busy   (busy),
    .ctl    (ctl)
  );

  cfs_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .value        (in_value),
    .ctl          (ctl),
    .status       (status),
    .res_valid    (out_valid),
    .res_pop_data (pop_data),
    .res_found    (out_found),
    .res_position (out_position),
    .res_count    (out_count),
    .res_full     (out_is_full),
    .res_empty    (out_is_empty),
    .res_refused  (out_refused)
  );

  assign out_pop_data = pop_data;

endmodule

`default_nettype wire

### verif/tb_circular_fifo_with_search_core.sv
// Testbench for circular_fifo_with_search_core: drives push, pop, find and clear commands,
// predicts each result with a ring-queue model and checks the results in order.
// Depends on cfs_pkg and circular_fifo_with_search_core.
`timescale 1ns / 100ps

module tb_circular_fifo_with_search_core;
  import cfs_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1600;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  typedef struct {
    logic signed [DATA_W-1:0] pop_data;
    logic                     found;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
    logic                     is_full;
    logic                     is_empty;
    logic                     refused;
  } fifo_result_t;

  class ring_queue_model;
    logic signed [DATA_W-1:0] words [DEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned held;
    int unsigned failures;
    fifo_result_t pending_results [$];

    function new();
      head     = 0;
      tail     = DEPTH - 1;
      held     = 0;
      failures = 0;
    endfunction

    function logic signed [DATA_W-1:0] held_at(int unsigned offset);
      return words[(head + offset) % DEPTH];
    endfunction

    function void note_command(cmd_t op, logic signed [DATA_W-1:0] value);
      fifo_result_t r;
      r = '{default: 0};
      case (op)
        CMD_PUSH: begin
          if (held == DEPTH) begin
            r.refused = 1'b1;
          end else begin
            tail = (tail + 1) % DEPTH;
            words[tail] = value;
            held++;
          end
        end
        CMD_POP: begin
          if (held == 0) begin
            r.refused = 1'b1;
          end else begin
            r.pop_data = words[head];
            head = (head + 1) % DEPTH;
            held--;
          end
        end
        CMD_FIND: begin
          for (int unsigned k = 0; k < held; k++) begin
            if (words[(head + k) % DEPTH] == value) begin
              r.found    = 1'b1;
              r.position = POS_W'(k);
              break;
            end
          end
        end
        default: begin
          held = 0;
          head = (tail + 1) % DEPTH;
        end
      endcase
      r.count    = CNT_W'(held);
      r.is_full  = (held == DEPTH);
      r.is_empty = (held == 0);
      pending_results.push_back(r);
    endfunction

    function void check_result(fifo_result_t got);
      fifo_result_t want;
      if (pending_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: pop_data=%0d found=%0b position=%0d count=%0d",
                   got.pop_data, got.found, got.position, got.count);
        return;
      end
      want = pending_results.pop_front();
      if (got.pop_data !== want.pop_data || got.found !== want.found ||
          got.position !== want.position || got.count !== want.count ||
          got.is_full !== want.is_full || got.is_empty !== want.is_empty ||
          got.refused !== want.refused) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch exp: data=%0d fnd=%0b pos=%0d cnt=%0d full=%0b empty=%0b ref=%0b",
                   want.pop_data, want.found, want.position, want.count,
                   want.is_full, want.is_empty, want.refused);
          $display("         act: data=%0d fnd=%0b pos=%0d cnt=%0d full=%0b empty=%0b ref=%0b",
                   got.pop_data, got.found, got.position, got.count,
                   got.is_full, got.is_empty, got.refused);
        end
      end
    endfunction
  endclass

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     start    = 1'b0;
  logic [CMD_W-1:0]         in_cmd   = CMD_PUSH;
  logic signed [DATA_W-1:0] in_value = '0;
  logic                     busy;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_pop_data;
  logic                     out_found;
  logic [POS_W-1:0]         out_position;
  logic [CNT_W-1:0]         out_count;
  logic                     out_is_full;
  logic                     out_is_empty;
  logic                     out_refused;
  int unsigned              cycles   = 0;
  ring_queue_model          queue_model = new();

  circular_fifo_with_search_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_pop_data (out_pop_data),
    .out_found    (out_found),
    .out_position (out_position),
    .out_count    (out_count),
    .out_is_full  (out_is_full),
    .out_is_empty (out_is_empty),
    .out_refused  (out_refused)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      queue_model.check_result('{out_pop_data, out_found, out_position, out_count,
                                 out_is_full, out_is_empty, out_refused});
  end

  task automatic send(input cmd_t op, input logic signed [DATA_W-1:0] value);
    start    <= 1'b1;
    in_cmd   <= op;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    queue_model.note_command(op, value);
  endtask

  task automatic idle(input int unsigned n);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (queue_model.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned gap_len(input bit burst);
    int unsigned r;
    r = $urandom_range(99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(40, 20);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return $urandom_range(7);
    if (r < 40) begin
      case ($urandom_range(3))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic cmd_t pick_cmd(input int unsigned mode);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 1) return CMD_CLEAR;
    if (r < 25) return CMD_FIND;
    case (mode)
      0:       return (r < 85) ? CMD_PUSH : CMD_POP;
      1:       return (r < 40) ? CMD_PUSH : CMD_POP;
      default: return (r < 62) ? CMD_PUSH : CMD_POP;
    endcase
  endfunction

  initial begin
    cmd_t                     op;
    logic signed [DATA_W-1:0] value;
    int unsigned              mode;
    int unsigned              left_in_mode;
    bit                       burst;

    mode         = 2;
    left_in_mode = 0;
    burst        = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty queue, extremes, duplicates, hit and miss, full, clear
    send(CMD_POP, '0);
    send(CMD_FIND, 32'sd5);
    send(CMD_PUSH, WORD_MIN);
    idle(2);
    send(CMD_PUSH, WORD_MAX);
    send(CMD_PUSH, '0);
    send(CMD_PUSH, -1);
    send(CMD_PUSH, -1);
    send(CMD_FIND, -1);
    send(CMD_FIND, WORD_MIN);
    idle(1);
    send(CMD_FIND, 32'sd1);
    send(CMD_POP, '0);
    for (int i = 0; i < 12; i++) send(CMD_PUSH, 32'sh5A5A_0000 + i);
    send(CMD_PUSH, 32'sd77);
    send(CMD_FIND, 32'sh5A5A_000B);
    send(CMD_POP, '0);
    send(CMD_CLEAR, '0);
    send(CMD_POP, '0);
    drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (left_in_mode == 0) begin
        mode         = $urandom_range(2);
        left_in_mode = $urandom_range(80, 20);
        burst        = ($urandom_range(3) == 0);
      end
      left_in_mode--;
      op = pick_cmd(mode);
      if (op == CMD_FIND && queue_model.held != 0 && $urandom_range(99) < 65)
        value = queue_model.held_at($urandom_range(queue_model.held - 1));
      else
        value = pick_value();
      send(op, value);
      if (i % 300 == 299)
        drain();
      else
        idle(gap_len(burst));
    end

    drain();
    repeat (DEPTH + 4) @(posedge clk);
    if (queue_model.failures == 0 && queue_model.pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
